### rtl/spc_pkg.sv
package spc_pkg;

	localparam int NUM_BANDS_DEF   = 248;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int BAND_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int REF_W      = 16;
	localparam int ABS_W      = 24;
	localparam int ACC_W      = 40;
	localparam int SQ_W       = 2 * REF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PCT_W      = 10;
	localparam int COS_W      = 7;
	localparam int CLASS_W    = 2;

	localparam int MUL_AW  = 2 * ACC_W;
	localparam int MUL_BW  = ACC_W;
	localparam int PROD_W  = MUL_AW + MUL_BW;
	localparam int DIGIT_W = 8;
	localparam int DIGITS  = MUL_BW / DIGIT_W;

	localparam logic [MUL_BW-1:0] L1_SCALE  = MUL_BW'(100);
	localparam logic [MUL_BW-1:0] COS_SCALE = MUL_BW'(10000);

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic METHOD_L1  = 1'b0;
	localparam logic METHOD_SAM = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METHOD     = 3'd0,
		REG_GATE_BAND  = 3'd1,
		REG_GATE_LEVEL = 3'd2,
		REG_UPPER_PCT  = 3'd3,
		REG_LOWER_PCT  = 3'd4,
		REG_COS_PCT    = 3'd5
	} reg_idx_t;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_BACKGROUND = 2'd0,
		CLASS_NONE       = 2'd1,
		CLASS_FIRST      = 2'd2,
		CLASS_SECOND     = 2'd3
	} class_t;

	localparam logic              METHOD_RST     = METHOD_SAM;
	localparam logic [BAND_W-1:0] GATE_BAND_RST  = 8'd17;
	localparam logic [SAMPLE_W-1:0] GATE_LEVEL_RST = 16'd45;
	localparam logic [PCT_W-1:0]  UPPER_PCT_RST  = 10'd120;
	localparam logic [PCT_W-1:0]  LOWER_PCT_RST  = 10'd95;
	localparam logic [COS_W-1:0]  COS_PCT_RST    = 7'd80;

	typedef struct packed {
		logic                kind;
		logic [BAND_W-1:0]   band;
		logic [SAMPLE_W-1:0] sample;
		logic [REF_W-1:0]    ref_first;
		logic [REF_W-1:0]    ref_second;
		logic                band_used;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] pixel_class;
	} result_t;

	typedef struct packed {
		logic                method;
		logic [BAND_W-1:0]   gate_band;
		logic [SAMPLE_W-1:0] gate_level;
		logic [PCT_W-1:0]    upper_pct;
		logic [PCT_W-1:0]    lower_pct;
		logic [COS_W-1:0]    cos_pct;
	} cfg_t;

	typedef struct packed {
		logic [ABS_W-1:0] abs_first;
		logic [ABS_W-1:0] abs_second;
		logic [ACC_W-1:0] dot_first;
		logic [ACC_W-1:0] dot_second;
		logic [ACC_W-1:0] energy_first;
		logic [ACC_W-1:0] energy_second;
		logic [ACC_W-1:0] energy_pixel;
		logic             dark;
	} acc_t;

endpackage

### rtl/spc_stream_if.sv
interface spc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
	modport mon(input valid, input ready, input data);
endinterface

### rtl/spc_accum.sv
module spc_accum #(
	parameter int NUM_BANDS   = spc_pkg::NUM_BANDS_DEF,
	parameter int SAMPLE_BITS = spc_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  spc_pkg::item_t item,
	input  spc_pkg::cfg_t  cfg,
	input  logic          clr,
	output logic          fin,
	output spc_pkg::acc_t  acc
);

	localparam int DEPTH = (NUM_BANDS < 256) ? NUM_BANDS : 256;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MEM_W = 1 + 2 * spc_pkg::REF_W;

	logic [MEM_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;

	logic [IDX_W-1:0]       addr;
	logic                   in_range;
	logic [SAMPLE_BITS-1:0] smp;
	logic                   is_load;
	logic                   is_pixel;

	logic                   vld_s1;
	logic [MEM_W-1:0]       rd_s1;
	logic                   wr_s1;
	logic                   inr_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic                   last_s1;
	logic                   dark_s1;

	logic [spc_pkg::REF_W-1:0] r1, r2, sx, d1, d2;
	logic                      use_band;

	logic                      vld_s2;
	logic                      last_s2;
	logic                      dark_s2;
	logic [spc_pkg::REF_W-1:0] d1_s2, d2_s2;
	logic [spc_pkg::SQ_W-1:0]  rs1_s2, rs2_s2, rr1_s2, rr2_s2, ss_s2;

	logic fin_q;
	spc_pkg::acc_t acc_q;

	function automatic logic [spc_pkg::ABS_W-1:0] sat_abs(
		input logic [spc_pkg::ABS_W-1:0] a,
		input logic [spc_pkg::REF_W-1:0] b
	);
		logic [spc_pkg::ABS_W:0] s;
		s = {1'b0, a} + (spc_pkg::ABS_W + 1)'(b);
		return s[spc_pkg::ABS_W] ? '1 : s[spc_pkg::ABS_W-1:0];
	endfunction

	function automatic logic [spc_pkg::ACC_W-1:0] sat_acc(
		input logic [spc_pkg::ACC_W-1:0] a,
		input logic [spc_pkg::SQ_W-1:0]  b
	);
		logic [spc_pkg::ACC_W:0] s;
		s = {1'b0, a} + (spc_pkg::ACC_W + 1)'(b);
		return s[spc_pkg::ACC_W] ? '1 : s[spc_pkg::ACC_W-1:0];
	endfunction

	assign addr     = IDX_W'(item.band);
	assign in_range = int'(item.band) < NUM_BANDS;
	assign smp      = SAMPLE_BITS'(item.sample);
	assign is_load  = take && (item.kind == spc_pkg::KIND_LOAD);
	assign is_pixel = take && (item.kind == spc_pkg::KIND_PIXEL);

	always_ff @(posedge clk) begin
		if (is_load && in_range) begin
			mem[addr] <= {item.band_used, item.ref_second, item.ref_first};
		end
		rd_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			fin_q     <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (is_load && in_range) begin
				written_q[addr] <= 1'b1;
			end
			vld_s1 <= is_pixel;
			vld_s2 <= vld_s1;
			fin_q  <= vld_s2 && last_s2;
			if (clr) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q.abs_first     <= sat_abs(acc_q.abs_first, d1_s2);
				acc_q.abs_second    <= sat_abs(acc_q.abs_second, d2_s2);
				acc_q.dot_first     <= sat_acc(acc_q.dot_first, rs1_s2);
				acc_q.dot_second    <= sat_acc(acc_q.dot_second, rs2_s2);
				acc_q.energy_first  <= sat_acc(acc_q.energy_first, rr1_s2);
				acc_q.energy_second <= sat_acc(acc_q.energy_second, rr2_s2);
				acc_q.energy_pixel  <= sat_acc(acc_q.energy_pixel, ss_s2);
				if (dark_s2) begin
					acc_q.dark <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_s1   <= written_q[addr];
		inr_s1  <= in_range;
		smp_s1  <= smp;
		last_s1 <= item.last;
		dark_s1 <= (item.band == cfg.gate_band) &&
			(spc_pkg::SAMPLE_W'(smp) < cfg.gate_level);
	end

	always_comb begin
		r1       = rd_s1[spc_pkg::REF_W-1:0];
		r2       = rd_s1[2*spc_pkg::REF_W-1:spc_pkg::REF_W];
		sx       = spc_pkg::REF_W'(smp_s1);
		use_band = inr_s1 && (wr_s1 ? rd_s1[MEM_W-1] : 1'b1);
		d1       = (r1 > sx) ? r1 - sx : sx - r1;
		d2       = (r2 > sx) ? r2 - sx : sx - r2;
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		dark_s2 <= dark_s1;
		d1_s2   <= use_band ? d1 : '0;
		d2_s2   <= use_band ? d2 : '0;
		rs1_s2  <= use_band ? r1 * sx : '0;
		rs2_s2  <= use_band ? r2 * sx : '0;
		rr1_s2  <= use_band ? r1 * r1 : '0;
		rr2_s2  <= use_band ? r2 * r2 : '0;
		ss_s2   <= use_band ? sx * sx : '0;
	end

	assign fin = fin_q;
	assign acc = acc_q;

endmodule

### rtl/spc_mul.sv
module spc_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [spc_pkg::MUL_AW-1:0]  a,
	input  logic [spc_pkg::MUL_BW-1:0]  b,
	output logic                        done,
	output logic [spc_pkg::PROD_W-1:0]  p
);

	localparam int CNT_W = $clog2(spc_pkg::DIGITS + 1);

	logic                                      run_q;
	logic                                      done_q;
	logic [CNT_W-1:0]                          cnt_q;
	logic [spc_pkg::MUL_AW-1:0]                a_q;
	logic [spc_pkg::MUL_BW-1:0]                b_q;
	logic [spc_pkg::PROD_W-1:0]                acc_q;
	logic [spc_pkg::DIGIT_W-1:0]               digit;
	logic [spc_pkg::MUL_AW+spc_pkg::DIGIT_W-1:0] part;

	assign digit = b_q[spc_pkg::MUL_BW-1 -: spc_pkg::DIGIT_W];
	assign part  = a_q * digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(spc_pkg::DIGITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= (acc_q << spc_pkg::DIGIT_W) + spc_pkg::PROD_W'(part);
			b_q   <= b_q << spc_pkg::DIGIT_W;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

### rtl/spc_classify.sv
module spc_classify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fin,
	input  spc_pkg::acc_t        acc,
	input  spc_pkg::cfg_t        cfg,
	output logic                 clr,
	spc_stream_if.source         res
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_ISSUE,
		C_WAIT,
		C_OUT
	} state_t;

	typedef enum logic [3:0] {
		ST_SQ1,
		ST_SQ2,
		ST_GA,
		ST_GB,
		ST_LA,
		ST_TA,
		ST_RA,
		ST_LB,
		ST_TB,
		ST_RB,
		ST_L1H,
		ST_L1U,
		ST_L1L
	} step_t;

	state_t                        state_q;
	step_t                         step_q;
	spc_pkg::class_t               class_q;
	logic                          clr_q;

	logic [spc_pkg::MUL_AW-1:0]    sq1_q, sq2_q;
	logic [spc_pkg::PROD_W-1:0]    h_q;
	logic                          gt_q;
	logic                          ok_a_q;

	logic [spc_pkg::MUL_AW-1:0]    op_a;
	logic [spc_pkg::MUL_BW-1:0]    op_b;
	logic [2*spc_pkg::COS_W-1:0]   c2;
	logic                          mul_start;
	logic                          mul_done;
	logic [spc_pkg::PROD_W-1:0]    prod;
	logic                          h_gt;
	logic                          h_lt;
	logic                          ok_b;

	assign c2        = cfg.cos_pct * cfg.cos_pct;
	assign mul_start = (state_q == C_ISSUE);
	assign h_gt      = h_q > prod;
	assign h_lt      = h_q < prod;
	assign ok_b      = (acc.dot_second != '0) && h_gt;

	always_comb begin
		case (step_q)
			ST_SQ1: begin
				op_a = spc_pkg::MUL_AW'(acc.dot_first);
				op_b = acc.dot_first;
			end
			ST_SQ2: begin
				op_a = spc_pkg::MUL_AW'(acc.dot_second);
				op_b = acc.dot_second;
			end
			ST_GA: begin
				op_a = sq1_q;
				op_b = acc.energy_second;
			end
			ST_GB: begin
				op_a = sq2_q;
				op_b = acc.energy_first;
			end
			ST_LA: begin
				op_a = sq1_q;
				op_b = spc_pkg::COS_SCALE;
			end
			ST_TA: begin
				op_a = spc_pkg::MUL_AW'(acc.energy_first);
				op_b = acc.energy_pixel;
			end
			ST_RA, ST_RB: begin
				op_a = (step_q == ST_RA) ? sq1_q : sq2_q;
				op_b = spc_pkg::MUL_BW'(c2);
			end
			ST_LB: begin
				op_a = sq2_q;
				op_b = spc_pkg::COS_SCALE;
			end
			ST_TB: begin
				op_a = spc_pkg::MUL_AW'(acc.energy_second);
				op_b = acc.energy_pixel;
			end
			ST_L1H: begin
				op_a = spc_pkg::MUL_AW'(acc.abs_first);
				op_b = spc_pkg::L1_SCALE;
			end
			ST_L1U: begin
				op_a = spc_pkg::MUL_AW'(acc.abs_second);
				op_b = spc_pkg::MUL_BW'(cfg.upper_pct);
			end
			ST_L1L: begin
				op_a = spc_pkg::MUL_AW'(acc.abs_second);
				op_b = spc_pkg::MUL_BW'(cfg.lower_pct);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	spc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= ST_SQ1;
			class_q <= spc_pkg::CLASS_BACKGROUND;
			clr_q   <= 1'b0;
		end else begin
			clr_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (fin) begin
						if (acc.dark) begin
							class_q <= spc_pkg::CLASS_BACKGROUND;
							clr_q   <= 1'b1;
							state_q <= C_OUT;
						end else if (cfg.method == spc_pkg::METHOD_L1 &&
							acc.abs_first == '0) begin
							class_q <= spc_pkg::CLASS_NONE;
							clr_q   <= 1'b1;
							state_q <= C_OUT;
						end else begin
							step_q  <= (cfg.method == spc_pkg::METHOD_SAM) ? ST_SQ1 : ST_L1H;
							state_q <= C_ISSUE;
						end
					end
				end
				C_ISSUE: begin
					state_q <= C_WAIT;
				end
				C_WAIT: begin
					if (mul_done) begin
						state_q <= C_ISSUE;
						case (step_q)
							ST_SQ1: step_q <= ST_SQ2;
							ST_SQ2: step_q <= ST_GA;
							ST_GA:  step_q <= ST_GB;
							ST_GB:  step_q <= ST_LA;
							ST_LA:  step_q <= ST_TA;
							ST_TA:  step_q <= ST_RA;
							ST_RA:  step_q <= ST_LB;
							ST_LB:  step_q <= ST_TB;
							ST_TB:  step_q <= ST_RB;
							ST_L1H: step_q <= ST_L1U;
							ST_L1U: step_q <= ST_L1L;
							ST_RB: begin
								if (ok_a_q && gt_q) begin
									class_q <= spc_pkg::CLASS_FIRST;
								end else if (ok_b) begin
									class_q <= spc_pkg::CLASS_SECOND;
								end else begin
									class_q <= spc_pkg::CLASS_NONE;
								end
								clr_q   <= 1'b1;
								state_q <= C_OUT;
							end
							ST_L1L: begin
								if (gt_q) begin
									class_q <= spc_pkg::CLASS_SECOND;
								end else if (h_lt) begin
									class_q <= spc_pkg::CLASS_FIRST;
								end else begin
									class_q <= spc_pkg::CLASS_NONE;
								end
								clr_q   <= 1'b1;
								state_q <= C_OUT;
							end
							default: state_q <= C_IDLE;
						endcase
					end
				end
				C_OUT: begin
					if (res.ready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_WAIT && mul_done) begin
			case (step_q)
				ST_SQ1, ST_TA: sq1_q <= prod[spc_pkg::MUL_AW-1:0];
				ST_SQ2, ST_TB: sq2_q <= prod[spc_pkg::MUL_AW-1:0];
				ST_GA, ST_LA, ST_LB, ST_L1H: h_q <= prod;
				ST_GB, ST_L1U: gt_q <= h_gt;
				ST_RA: ok_a_q <= (acc.dot_first != '0) && h_gt;
				default: ;
			endcase
		end
	end

	assign clr                  = clr_q;
	assign res.valid            = (state_q == C_OUT);
	assign res.data.pixel_class = class_q;

endmodule

### rtl/spectral_pixel_classifier_unit.sv
// Two-class hyperspectral pixel classifier.
// Channel item (valid/ready, payload spc_pkg::item_t): kind 0 loads the two
// reference values and the band-used flag of one band into the signature
// memory; kind 1 streams pixel samples in band order, last marks the end.
// Channel result (valid/ready, payload spc_pkg::result_t): one pixel_class per
// pixel, sent after its last sample.
// Configuration: cfg_we/cfg_idx/cfg_wdata, to be written while the block is
// idle (the block does not enforce this). Throughput: loads and samples are
// taken one per cycle while item.ready is high. A sample passes the signature
// memory read, the difference/product stage and the accumulators in turn.
// After a last sample, item.ready stays low until the result transaction
// completes. Classification runs on one shared 80x8 multiplier; background
// and an L1 pixel with zero first distance are classified without it, the L1
// ratio and the spectral angle method by a sequence of products on it.
// Reset clears the configuration to its defaults, the band-used flags to one
// and the accumulators to zero; signatures are undefined until loaded.
// While result.ready is low, the result holds and no new item is taken.
module spectral_pixel_classifier_unit #(
	parameter int NUM_BANDS   = spc_pkg::NUM_BANDS_DEF,
	parameter int SAMPLE_BITS = spc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	spc_stream_if.sink                        item,
	spc_stream_if.source                      result
);

	spc_pkg::cfg_t cfg_q;
	spc_pkg::acc_t acc;
	logic          pending_q;
	logic          take;
	logic          fin;
	logic          clr;

	assign take       = item.valid && item.ready;
	assign item.ready = !pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method     <= spc_pkg::METHOD_RST;
			cfg_q.gate_band  <= spc_pkg::GATE_BAND_RST;
			cfg_q.gate_level <= spc_pkg::GATE_LEVEL_RST;
			cfg_q.upper_pct  <= spc_pkg::UPPER_PCT_RST;
			cfg_q.lower_pct  <= spc_pkg::LOWER_PCT_RST;
			cfg_q.cos_pct    <= spc_pkg::COS_PCT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				spc_pkg::REG_METHOD:     cfg_q.method     <= cfg_wdata[0];
				spc_pkg::REG_GATE_BAND:  cfg_q.gate_band  <= cfg_wdata[spc_pkg::BAND_W-1:0];
				spc_pkg::REG_GATE_LEVEL: cfg_q.gate_level <= cfg_wdata[spc_pkg::SAMPLE_W-1:0];
				spc_pkg::REG_UPPER_PCT:  cfg_q.upper_pct  <= cfg_wdata[spc_pkg::PCT_W-1:0];
				spc_pkg::REG_LOWER_PCT:  cfg_q.lower_pct  <= cfg_wdata[spc_pkg::PCT_W-1:0];
				spc_pkg::REG_COS_PCT:    cfg_q.cos_pct    <= cfg_wdata[spc_pkg::COS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (result.valid && result.ready) begin
			pending_q <= 1'b0;
		end else if (take && item.data.kind == spc_pkg::KIND_PIXEL && item.data.last) begin
			pending_q <= 1'b1;
		end
	end

	spc_accum #(
		.NUM_BANDS   (NUM_BANDS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item.data),
		.cfg    (cfg_q),
		.clr    (clr),
		.fin    (fin),
		.acc    (acc)
	);

	spc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.fin    (fin),
		.acc    (acc),
		.cfg    (cfg_q),
		.clr    (clr),
		.res    (result)
	);

endmodule

### rtl/spc_checker.sv
module spc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         item_kind,
	input logic                         item_last,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [spc_pkg::CLASS_W-1:0]  result_class
);

	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind == spc_pkg::KIND_PIXEL && item_last
		|=> !item_ready)
		else $error("input taken after the end of a pixel");

	a_result_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("input ready while a result is pending");

	a_result_releases: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready |=> !result_valid && item_ready)
		else $error("result repeated or input not released");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_class))
		else $error("stalled result changed");

endmodule

bind spectral_pixel_classifier_unit spc_checker u_spc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_kind    (item.data.kind),
	.item_last    (item.data.last),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_class (result.data.pixel_class)
);

### tb/sv/tb_spectral_pixel_classifier_unit.sv
`timescale 1ns / 100ps

module tb_spectral_pixel_classifier_unit;

	localparam int NB           = spc_pkg::NUM_BANDS_DEF;
	localparam int IDLE_PCT     = 24;
	localparam int PHASES       = 10;
	localparam int CALM_PHASE   = 5;
	localparam int RANDOM_ITEMS = 1580;
	localparam int SAT_LEN      = 270;
	localparam int SETTLE       = 12;
	localparam int END_WAIT     = 120;
	localparam int QUIET_LIMIT  = 3000;

	typedef bit [127:0] wide_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	spc_stream_if #(.payload_t(spc_pkg::item_t))   item_ch ();
	spc_stream_if #(.payload_t(spc_pkg::result_t)) result_ch ();

	spectral_pixel_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #5 clk = ~clk;

	// classifier state as the block should hold it
	bit [spc_pkg::REF_W-1:0] sig_first [NB];
	bit [spc_pkg::REF_W-1:0] sig_second [NB];
	bit                      band_on [NB];
	bit [spc_pkg::ABS_W-1:0] dist_first, dist_second;
	bit [spc_pkg::ACC_W-1:0] corr_first, corr_second, pow_first, pow_second, pow_pixel;
	bit                      gated_dark;
	spc_pkg::cfg_t           cfg_now;

	// signatures as the stimulus has sent them
	bit [spc_pkg::REF_W-1:0] plan_first [NB];
	bit [spc_pkg::REF_W-1:0] plan_second [NB];

	spc_pkg::item_t  pending_items [$];
	spc_pkg::class_t expected_class [$];
	spc_pkg::class_t want_class;
	int              pushed_count, accepted_count, quiet_cycles, failures;
	bit              item_taken, calm;

	function automatic bit [spc_pkg::ABS_W-1:0] add_abs(bit [spc_pkg::ABS_W-1:0] a,
			bit [spc_pkg::REF_W-1:0] d);
		bit [spc_pkg::ABS_W:0] sum;
		sum = {1'b0, a} + (spc_pkg::ABS_W + 1)'(d);
		return sum[spc_pkg::ABS_W] ? '1 : sum[spc_pkg::ABS_W-1:0];
	endfunction

	function automatic bit [spc_pkg::ACC_W-1:0] add_acc(bit [spc_pkg::ACC_W-1:0] a,
			bit [spc_pkg::SQ_W-1:0] p);
		bit [spc_pkg::ACC_W:0] sum;
		sum = {1'b0, a} + (spc_pkg::ACC_W + 1)'(p);
		return sum[spc_pkg::ACC_W] ? '1 : sum[spc_pkg::ACC_W-1:0];
	endfunction

	function automatic bit angle_passes(bit [spc_pkg::ACC_W-1:0] corr,
			bit [spc_pkg::ACC_W-1:0] pow_ref);
		return corr != 0 && wide_t'(corr) * corr * 10000 >
			wide_t'(pow_ref) * pow_pixel * cfg_now.cos_pct * cfg_now.cos_pct;
	endfunction

	function automatic spc_pkg::class_t classify_pixel();
		if (gated_dark)
			return spc_pkg::CLASS_BACKGROUND;
		if (cfg_now.method == spc_pkg::METHOD_L1) begin
			if (dist_first == 0)
				return spc_pkg::CLASS_NONE;
			if (wide_t'(dist_first) * 100 > wide_t'(cfg_now.upper_pct) * dist_second)
				return spc_pkg::CLASS_SECOND;
			if (wide_t'(dist_first) * 100 < wide_t'(cfg_now.lower_pct) * dist_second)
				return spc_pkg::CLASS_FIRST;
			return spc_pkg::CLASS_NONE;
		end
		if (angle_passes(corr_first, pow_first) &&
				wide_t'(corr_first) * corr_first * pow_second >
				wide_t'(corr_second) * corr_second * pow_first)
			return spc_pkg::CLASS_FIRST;
		if (angle_passes(corr_second, pow_second))
			return spc_pkg::CLASS_SECOND;
		return spc_pkg::CLASS_NONE;
	endfunction

	task automatic absorb_item(input spc_pkg::item_t it);
		bit [spc_pkg::REF_W-1:0]    r1, r2;
		bit [spc_pkg::SAMPLE_W-1:0] s;
		s = it.sample;
		if (it.kind == spc_pkg::KIND_LOAD) begin
			if (it.band < NB) begin
				sig_first[it.band]  = it.ref_first;
				sig_second[it.band] = it.ref_second;
				band_on[it.band]    = it.band_used;
			end
		end else begin
			if (it.band == cfg_now.gate_band && s < cfg_now.gate_level)
				gated_dark = 1'b1;
			if (it.band < NB && band_on[it.band]) begin
				r1 = sig_first[it.band];
				r2 = sig_second[it.band];
				dist_first  = add_abs(dist_first, r1 > s ? r1 - s : s - r1);
				dist_second = add_abs(dist_second, r2 > s ? r2 - s : s - r2);
				corr_first  = add_acc(corr_first, spc_pkg::SQ_W'(r1) * s);
				corr_second = add_acc(corr_second, spc_pkg::SQ_W'(r2) * s);
				pow_first   = add_acc(pow_first, spc_pkg::SQ_W'(r1) * r1);
				pow_second  = add_acc(pow_second, spc_pkg::SQ_W'(r2) * r2);
				pow_pixel   = add_acc(pow_pixel, spc_pkg::SQ_W'(s) * s);
			end
			if (it.last) begin
				expected_class.push_back(classify_pixel());
				dist_first  = '0;
				dist_second = '0;
				corr_first  = '0;
				corr_second = '0;
				pow_first   = '0;
				pow_second  = '0;
				pow_pixel   = '0;
				gated_dark  = 1'b0;
			end
		end
	endtask

	task automatic push_load(input int band, input bit [spc_pkg::REF_W-1:0] r1, r2,
			input bit used, input bit last);
		spc_pkg::item_t it;
		it.kind       = spc_pkg::KIND_LOAD;
		it.band       = spc_pkg::BAND_W'(band);
		it.sample     = spc_pkg::SAMPLE_W'($urandom);
		it.ref_first  = r1;
		it.ref_second = r2;
		it.band_used  = used;
		it.last       = last;
		if (band < NB) begin
			plan_first[band]  = r1;
			plan_second[band] = r2;
		end
		pending_items.push_back(it);
		pushed_count++;
	endtask

	task automatic push_sample(input int band, input int value, input bit last);
		spc_pkg::item_t it;
		it.kind       = spc_pkg::KIND_PIXEL;
		it.band       = spc_pkg::BAND_W'(band);
		it.sample     = spc_pkg::SAMPLE_W'(value);
		it.ref_first  = spc_pkg::REF_W'($urandom);
		it.ref_second = spc_pkg::REF_W'($urandom);
		it.band_used  = 1'($urandom_range(1));
		it.last       = last;
		pending_items.push_back(it);
		pushed_count++;
	endtask

	// mostly pixels shaped after one signature, some noise and stray loads
	task automatic push_pixel(input int len);
		int start, band, base, value, gate_at, roll, flavor;
		roll    = $urandom_range(9);
		flavor  = roll < 4 ? 0 : roll < 7 ? 1 : roll < 9 ? 2 : 3;
		start   = $urandom_range(NB - 1);
		gate_at = ($urandom_range(2) == 0) ? $urandom_range(len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			band = (start + i) % 256;
			if ($urandom_range(99) < 4)
				band = $urandom_range(255);
			if (i == gate_at)
				band = int'(cfg_now.gate_band);
			if (band < NB && flavor < 2)
				base = flavor == 0 ? int'(plan_first[band]) : int'(plan_second[band]);
			else
				base = $urandom_range(65535);
			value = flavor == 3 ? 0 : base * $urandom_range(16, 8) / 12 + $urandom_range(1500);
			if (value > 65535)
				value = 65535;
			if (band == cfg_now.gate_band) begin
				case ($urandom_range(4))
					0, 1: if (cfg_now.gate_level != 0)
						value = $urandom_range(cfg_now.gate_level - 1);
					2: value = int'(cfg_now.gate_level);
					default: ;
				endcase
			end
			if ($urandom_range(99) < 3)
				push_load($urandom_range(255), spc_pkg::REF_W'($urandom),
					spc_pkg::REF_W'($urandom), $urandom_range(9) != 0,
					1'($urandom_range(1)));
			push_sample(band, value, i == len - 1);
		end
	endtask

	task automatic write_reg(input spc_pkg::reg_idx_t idx,
			input bit [spc_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spc_pkg::REG_METHOD:     cfg_now.method     = value[0];
			spc_pkg::REG_GATE_BAND:  cfg_now.gate_band  = value[spc_pkg::BAND_W-1:0];
			spc_pkg::REG_GATE_LEVEL: cfg_now.gate_level = value[spc_pkg::SAMPLE_W-1:0];
			spc_pkg::REG_UPPER_PCT:  cfg_now.upper_pct  = value[spc_pkg::PCT_W-1:0];
			spc_pkg::REG_LOWER_PCT:  cfg_now.lower_pct  = value[spc_pkg::PCT_W-1:0];
			spc_pkg::REG_COS_PCT:    cfg_now.cos_pct    = value[spc_pkg::COS_W-1:0];
			default: ;
		endcase
	endtask

	// hold until every transaction is taken and every class has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_count != pushed_count || expected_class.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_ch.valid || item_taken) begin
				if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					item_ch.data  <= pending_items.pop_front();
					item_ch.valid <= 1'b1;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				absorb_item(item_ch.data);
				accepted_count++;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_class.size() == 0) begin
					$error("pixel_class: unexpected transaction, expected none, actual %0d",
						result_ch.data.pixel_class);
					failures++;
				end else begin
					want_class = expected_class.pop_front();
					if (result_ch.data.pixel_class !== want_class) begin
						$error("pixel_class mismatch: expected %0d, actual %0d",
							want_class, result_ch.data.pixel_class);
						failures++;
					end
				end
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int budget, phase_base, random_base, len;
		int gb, gl, up, lo, cp;
		logic m;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = spc_pkg::REG_METHOD;
		cfg_wdata       = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		cfg_now.method     = spc_pkg::METHOD_RST;
		cfg_now.gate_band  = spc_pkg::GATE_BAND_RST;
		cfg_now.gate_level = spc_pkg::GATE_LEVEL_RST;
		cfg_now.upper_pct  = spc_pkg::UPPER_PCT_RST;
		cfg_now.lower_pct  = spc_pkg::LOWER_PCT_RST;
		cfg_now.cos_pct    = spc_pkg::COS_PCT_RST;
		foreach (band_on[b])
			band_on[b] = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load every band first so no sample reads an empty signature
		for (int b = 0; b < NB; b++) begin
			case (b)
				0:       push_load(b, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
				NB - 2:  push_load(b, 16'h0000, 16'h0000, 1'b1, 1'b0);
				NB - 1:  push_load(b, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
				default: push_load(b, spc_pkg::REF_W'($urandom), spc_pkg::REF_W'($urandom),
					1'b1, 1'($urandom_range(1)));
			endcase
		end

		push_sample(0, 0, 1'b1);
		push_sample(17, 44, 1'b1);
		push_sample(17, 45, 1'b1);
		push_sample(NB - 1, 65535, 1'b1);
		push_sample(255, 12345, 1'b1);
		push_load(250, spc_pkg::REF_W'($urandom), spc_pkg::REF_W'($urandom), 1'b1, 1'b1);
		push_sample(3, 30000, 1'b0);
		push_load(3, spc_pkg::REF_W'($urandom), spc_pkg::REF_W'($urandom), 1'b1, 1'b0);
		push_sample(4, 30000, 1'b1);
		push_load(10, spc_pkg::REF_W'($urandom), spc_pkg::REF_W'($urandom), 1'b0, 1'b0);
		push_sample(10, 5000, 1'b1);
		push_load(10, spc_pkg::REF_W'($urandom), spc_pkg::REF_W'($urandom), 1'b1, 1'b0);
		for (int b = 20; b < 24; b++)
			push_sample(b, int'(plan_first[b]), b == 23);
		for (int b = 30; b < 34; b++)
			push_sample(b, int'(plan_second[b]), b == 33);

		random_base = pushed_count;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			random_base = (ph == 0) ? pushed_count : random_base;
			calm = (ph == CALM_PHASE);
			case (ph)
				0: begin
					m = spc_pkg::METHOD_L1; gb = 0; gl = 0; up = 1000; lo = 0; cp = 100;
				end
				1: begin
					m = spc_pkg::METHOD_L1; gb = 247; gl = 65535; up = 0; lo = 1000; cp = 0;
				end
				2: begin
					m = spc_pkg::METHOD_SAM; gb = 250; gl = 1000; up = 120; lo = 95; cp = 0;
				end
				3: begin
					m = spc_pkg::METHOD_SAM; gb = 100; gl = 20000; up = 1000; lo = 1000;
					cp = 100;
				end
				4: begin
					m = spc_pkg::METHOD_SAM; gb = $urandom_range(247); gl = $urandom_range(3000);
					up = 120; lo = 95; cp = 127;
				end
				CALM_PHASE: begin
					m = spc_pkg::METHOD_L1; gb = $urandom_range(247); gl = $urandom_range(3000);
					up = 130; lo = 90; cp = 80;
				end
				6: begin
					m = spc_pkg::METHOD_L1; gb = 17; gl = 45; up = 120; lo = 95; cp = 80;
				end
				default: begin
					m = 1'($urandom_range(1)); gb = $urandom_range(247);
					gl = $urandom_range(4000);
					up = $urandom_range(200, 100); lo = $urandom_range(110, 60);
					cp = $urandom_range(100, 50);
				end
			endcase
			write_reg(spc_pkg::REG_METHOD, spc_pkg::CFG_DATA_W'(m));
			write_reg(spc_pkg::REG_GATE_BAND, spc_pkg::CFG_DATA_W'(gb));
			write_reg(spc_pkg::REG_GATE_LEVEL, spc_pkg::CFG_DATA_W'(gl));
			write_reg(spc_pkg::REG_UPPER_PCT, spc_pkg::CFG_DATA_W'(up));
			write_reg(spc_pkg::REG_LOWER_PCT, spc_pkg::CFG_DATA_W'(lo));
			write_reg(spc_pkg::REG_COS_PCT, spc_pkg::CFG_DATA_W'(cp));

			// drive the accumulators into saturation on a band with extreme signatures
			if (ph == 2 || ph == 6)
				for (int i = 0; i < SAT_LEN; i++)
					push_sample(ph == 2 ? NB - 1 : NB - 2, 65535, i == SAT_LEN - 1);

			budget     = (RANDOM_ITEMS - (pushed_count - random_base)) / (PHASES - ph);
			phase_base = pushed_count;
			while (pushed_count - phase_base < budget) begin
				if ($urandom_range(19) == 0)
					push_load($urandom_range(255), spc_pkg::REF_W'($urandom),
						spc_pkg::REF_W'($urandom), $urandom_range(9) != 0,
						1'($urandom_range(1)));
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
				push_pixel(len);
			end
		end

		wait_drained();
		calm = 1'b0;
		repeat (END_WAIT) @(negedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
